/* rtl/tfsc_pkg.sv */
// Shared types and constants for the texture fit scale/clamp core.
// Request/result payloads, config register set, queue entry and codes.
// No dependencies.
`default_nettype none
package tfsc_pkg;

    localparam int SIDE_BITS   = 8;
    localparam int MAX_SIDE    = 1 << SIDE_BITS;
    localparam int ADDR_BITS   = 2 * SIDE_BITS;
    localparam int PIXEL_BITS  = 32;
    localparam int SIZE_BITS   = 9;
    localparam int LOG2_BITS   = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] WIDE_MASK   = 32'((64'(1) << PIXEL_BITS) - 64'(1));
    localparam logic [31:0] NARROW_MASK = 32'h0000_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SCALE = 2'd1;
    localparam logic [1:0] MODE_CLAMP = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURF_W_LOG2  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURF_H_LOG2  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE_HORIZ   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE_VERT    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE_PIXELS  = 3'd6;

    typedef struct packed {
        logic                  operation;
        logic [SIDE_BITS-1:0]  pos_x;
        logic [SIDE_BITS-1:0]  pos_y;
        logic [31:0]           pixel_in;
    } t_request;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        outside_surface;
    } t_result;

    typedef struct packed {
        logic [SIZE_BITS-1:0] image_width;
        logic [SIZE_BITS-1:0] image_height;
        logic [LOG2_BITS-1:0] surface_width_log2;
        logic [LOG2_BITS-1:0] surface_height_log2;
        logic [1:0]           mode_horizontal;
        logic [1:0]           mode_vertical;
        logic                 wide_pixels;
    } t_cfg;

    typedef struct packed {
        logic                 operation;
        logic                 outside;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          pixel;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_qctl;

endpackage
`default_nettype wire

/* rtl/tfsc_front.sv */
// Front end: config registers, request classification and coordinate fit.
// Turns each accepted request into a queue entry. Depends on tfsc_pkg.
`default_nettype none
module tfsc_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tfsc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [tfsc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire tfsc_pkg::t_request                  i_request,
    output tfsc_pkg::t_cfg                           o_cfg,
    output tfsc_pkg::t_entry                         o_entry
);

    tfsc_pkg::t_cfg r_cfg;
    tfsc_pkg::t_cfg n_cfg;

    function automatic logic [tfsc_pkg::SIDE_BITS-1:0] fit_axis(
        input logic [tfsc_pkg::SIDE_BITS-1:0] dst,
        input logic [1:0]                     mode,
        input logic [tfsc_pkg::SIZE_BITS-1:0] size,
        input logic [tfsc_pkg::LOG2_BITS-1:0] lg
    );
        logic [tfsc_pkg::SIZE_BITS-1:0]                     sz;
        logic [tfsc_pkg::SIZE_BITS-1:0]                     lim;
        logic [tfsc_pkg::SIZE_BITS+tfsc_pkg::SIDE_BITS-1:0] prod;
        logic [tfsc_pkg::SIZE_BITS+tfsc_pkg::SIDE_BITS-1:0] shf;
        logic [tfsc_pkg::SIDE_BITS-1:0]                     res;
        sz   = (size == '0) ? tfsc_pkg::SIZE_BITS'(1) : size;
        lim  = sz - tfsc_pkg::SIZE_BITS'(1);
        prod = (tfsc_pkg::SIZE_BITS+tfsc_pkg::SIDE_BITS)'(dst) *
               (tfsc_pkg::SIZE_BITS+tfsc_pkg::SIDE_BITS)'(sz);
        shf  = prod >> lg;
        case (mode)
            tfsc_pkg::MODE_SCALE: res = shf[tfsc_pkg::SIDE_BITS-1:0];
            tfsc_pkg::MODE_CLAMP: begin
                res = ({1'b0, dst} < lim) ? dst : lim[tfsc_pkg::SIDE_BITS-1:0];
            end
            default: res = dst;
        endcase
        return res;
    endfunction

    function automatic logic beyond(
        input logic [tfsc_pkg::SIDE_BITS-1:0] pos,
        input logic [tfsc_pkg::LOG2_BITS-1:0] lg
    );
        logic r;
        if (lg >= tfsc_pkg::LOG2_BITS'(tfsc_pkg::SIDE_BITS)) begin
            r = 1'b0;
        end else begin
            r = (pos >> lg) != '0;
        end
        return r;
    endfunction

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                tfsc_pkg::CFG_IMAGE_WIDTH:  n_cfg.image_width         = i_cfg_data;
                tfsc_pkg::CFG_IMAGE_HEIGHT: n_cfg.image_height        = i_cfg_data;
                tfsc_pkg::CFG_SURF_W_LOG2:  n_cfg.surface_width_log2  = i_cfg_data[3:0];
                tfsc_pkg::CFG_SURF_H_LOG2:  n_cfg.surface_height_log2 = i_cfg_data[3:0];
                tfsc_pkg::CFG_MODE_HORIZ:   n_cfg.mode_horizontal     = i_cfg_data[1:0];
                tfsc_pkg::CFG_MODE_VERT:    n_cfg.mode_vertical       = i_cfg_data[1:0];
                tfsc_pkg::CFG_WIDE_PIXELS:  n_cfg.wide_pixels         = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width         <= tfsc_pkg::SIZE_BITS'(1);
            r_cfg.image_height        <= tfsc_pkg::SIZE_BITS'(1);
            r_cfg.surface_width_log2  <= '0;
            r_cfg.surface_height_log2 <= '0;
            r_cfg.mode_horizontal     <= tfsc_pkg::MODE_NONE;
            r_cfg.mode_vertical       <= tfsc_pkg::MODE_NONE;
            r_cfg.wide_pixels         <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    logic [tfsc_pkg::SIDE_BITS-1:0] sx;
    logic [tfsc_pkg::SIDE_BITS-1:0] sy;

    always_comb begin
        sx = fit_axis(i_request.pos_x, r_cfg.mode_horizontal, r_cfg.image_width,
                      r_cfg.surface_width_log2);
        sy = fit_axis(i_request.pos_y, r_cfg.mode_vertical, r_cfg.image_height,
                      r_cfg.surface_height_log2);
        o_entry.operation = i_request.operation;
        o_entry.pixel     = i_request.pixel_in;
        if (i_request.operation == tfsc_pkg::OP_WRITE) begin
            o_entry.outside = 1'b0;
            o_entry.addr    = {i_request.pos_y, i_request.pos_x};
        end else begin
            o_entry.outside = beyond(i_request.pos_x, r_cfg.surface_width_log2) ||
                              beyond(i_request.pos_y, r_cfg.surface_height_log2);
            o_entry.addr    = {sy, sx};
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* rtl/tfsc_queue.sv */
// Short request queue between the front end and the store back end.
// Depends on tfsc_pkg.
`default_nettype none
module tfsc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_pop,
    input  wire tfsc_pkg::t_entry  i_entry,
    output tfsc_pkg::t_entry       o_entry,
    output tfsc_pkg::t_qctl        o_ctl
);

    tfsc_pkg::t_entry r_mem [tfsc_pkg::QUEUE_DEPTH];
    logic [tfsc_pkg::QPTR_BITS-1:0] r_wptr, r_rptr;
    logic [tfsc_pkg::QPTR_BITS:0]   r_count;
    logic                           full, empty, do_push, do_pop;

    assign full    = r_count == (tfsc_pkg::QPTR_BITS+1)'(tfsc_pkg::QUEUE_DEPTH);
    assign empty   = r_count == '0;
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_entry;
    end

    assign o_entry   = r_mem[r_rptr];
    assign o_ctl.push  = do_push;
    assign o_ctl.pop   = do_pop;
    assign o_ctl.full  = full;
    assign o_ctl.empty = empty;

endmodule
`default_nettype wire

/* rtl/tfsc_back.sv */
// Back end: pixel store access and result register with pixel mask.
// Holds the 64K x 32 pixel store. Depends on tfsc_pkg.
`default_nettype none
module tfsc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tfsc_pkg::t_entry  i_entry,
    input  wire logic              i_wide,
    output logic                   o_valid,
    output tfsc_pkg::t_result      o_result
);

    logic [31:0] r_store [1 << tfsc_pkg::ADDR_BITS];
    logic [31:0] r_rdata;
    logic        r_rd_valid, r_rd_outside;
    logic        r_out_valid;
    tfsc_pkg::t_result r_out, n_out;

    always_ff @(posedge i_clk) begin
        if (i_valid && i_entry.operation == tfsc_pkg::OP_WRITE) begin
            r_store[i_entry.addr] <= i_entry.pixel;
        end
        r_rdata <= r_store[i_entry.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid  <= i_valid && i_entry.operation == tfsc_pkg::OP_READ;
            r_out_valid <= r_rd_valid;
        end
        r_rd_outside <= i_entry.outside;
        r_out        <= n_out;
    end

    always_comb begin
        n_out.outside_surface = r_rd_outside;
        if (r_rd_outside) begin
            n_out.pixel_out = '0;
        end else begin
            n_out.pixel_out = r_rdata & (i_wide ? tfsc_pkg::WIDE_MASK : tfsc_pkg::NARROW_MASK);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

/* rtl/texture_fit_scale_clamp_core.sv */
// Texture fit scale/clamp core: pixel store with per-axis fitted reads.
// An accepted read passes the queue, the read-data and the result registers.
// One request per cycle unless busy; the store back end drains one entry a cycle.
// busy rises only when the front-end queue is full; results cannot be stalled.
// Synchronous active-low reset restores config defaults and empties the pipeline;
// store contents are undefined until written. Depends on tfsc_pkg and submodules.
`default_nettype none
module texture_fit_scale_clamp_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire tfsc_pkg::t_request                  i_request,
    output logic                                     o_res_valid,
    output tfsc_pkg::t_result                        o_result,
    input  wire logic                                i_cfg_we,
    input  wire logic [tfsc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [tfsc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    tfsc_pkg::t_cfg   cfg;
    tfsc_pkg::t_entry front_entry, q_entry;
    tfsc_pkg::t_qctl  qctl;

    tfsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_request  (i_request),
        .o_cfg      (cfg),
        .o_entry    (front_entry)
    );

    tfsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_start),
        .i_pop   (1'b1),
        .i_entry (front_entry),
        .o_entry (q_entry),
        .o_ctl   (qctl)
    );

    tfsc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qctl.pop),
        .i_entry  (q_entry),
        .i_wide   (cfg.wide_pixels),
        .o_valid  (o_res_valid),
        .o_result (o_result)
    );

    assign o_busy = qctl.full;

endmodule
`default_nettype wire

/* rtl/tfsc_checker.sv */
// Port-level checker for texture_fit_scale_clamp_core, bound to the top level.
// Depends on tfsc_pkg.
`default_nettype none
module tfsc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic               o_busy,
    input wire tfsc_pkg::t_request i_request,
    input wire logic               o_res_valid,
    input wire tfsc_pkg::t_result  o_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result strobe right after reset");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.outside_surface) |-> (o_result.pixel_out == '0))
        else $error("outside read returned nonzero pixel");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_request.operation == tfsc_pkg::OP_READ)
        |-> ##3 o_res_valid)
        else $error("read request without result");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_request.operation == tfsc_pkg::OP_WRITE)
        |-> ##3 !o_res_valid)
        else $error("write request produced a result");

endmodule

bind texture_fit_scale_clamp_core tfsc_checker u_tfsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_request   (i_request),
    .o_res_valid (o_res_valid),
    .o_result    (o_result)
);
`default_nettype wire
